// ----- hw/rtl/rtt_pkg.sv -----
// Shared definitions for the redo transaction table: default sizes, item codes,
// entry status codes and the control group broadcast along the cell chain.
// No dependencies.
`default_nettype none

package rtt_pkg;

  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned TridBitsDef   = 16;
  localparam int unsigned LsnBitsDef    = 48;

  typedef enum logic [1:0] {
    FUNC_RECORD   = 2'd0,
    FUNC_FINALIZE = 2'd1,
    FUNC_LOOKUP   = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_LOGICAL  = 2'd0,
    KIND_COMMIT   = 2'd1,
    KIND_ROLLBACK = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OPEN     = 2'd0,
    ST_COMMIT   = 2'd1,
    ST_ROLLBACK = 2'd2
  } status_e;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic shift;       // take the entry of the neighbour above
    logic ins_en;      // load the insert bus if the index is ours
    logic upd_en;      // close the newest open entry of the captured id
    logic upd_commit;  // close as committed, else rolled back
    logic capture;     // register the id compare
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rtt_cell.sv -----
// One table entry of the redo transaction table chain.
// Depends on rtt_pkg.
`default_nettype none

module rtt_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned TABLE_DEPTH = rtt_pkg::TableDepthDef,
  parameter int unsigned TRID_BITS   = rtt_pkg::TridBitsDef,
  parameter int unsigned LSN_BITS    = rtt_pkg::LsnBitsDef,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rtt_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [CNT_W-1:0]     count_i,
  input  wire logic [TRID_BITS-1:0] tid_i,
  input  wire logic [LSN_BITS-1:0]  upd_lsn_i,
  input  wire logic [IDX_W-1:0]     ins_idx_i,
  input  wire logic [TRID_BITS-1:0] ins_trid_i,
  input  wire logic [LSN_BITS-1:0]  ins_first_i,
  input  wire logic [LSN_BITS-1:0]  ins_end_i,
  input  wire logic [1:0]           ins_status_i,
  input  wire logic [TRID_BITS-1:0] up_trid_i,
  input  wire logic [LSN_BITS-1:0]  up_first_i,
  input  wire logic [LSN_BITS-1:0]  up_end_i,
  input  wire logic [1:0]           up_status_i,
  input  wire logic                 found_above_i,
  output logic [TRID_BITS-1:0]      trid_o,
  output logic [LSN_BITS-1:0]       first_o,
  output logic [LSN_BITS-1:0]       end_o,
  output logic [1:0]                status_o,
  output logic                      found_o,
  output logic                      open_hit_o
);
  import rtt_pkg::*;

  logic [TRID_BITS-1:0] trid_q;
  logic [LSN_BITS-1:0]  first_q, end_q;
  logic [1:0]           status_q;
  logic                 match_q;
  logic                 newest;

  // newest entry of the id: matches here and nowhere further up the chain
  assign newest     = match_q && !found_above_i;
  assign found_o    = match_q || found_above_i;
  assign open_hit_o = newest && (status_q == ST_OPEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.capture) begin
        match_q <= (CNT_W'(IDX) < count_i) && (trid_q == tid_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en && (ins_idx_i == IDX_W'(IDX))) begin
      trid_q   <= ins_trid_i;
      first_q  <= ins_first_i;
      end_q    <= ins_end_i;
      status_q <= ins_status_i;
    end else if (ctrl_i.shift) begin
      trid_q   <= up_trid_i;
      first_q  <= up_first_i;
      end_q    <= up_end_i;
      status_q <= up_status_i;
    end else if (ctrl_i.upd_en && open_hit_o) begin
      status_q <= ctrl_i.upd_commit ? ST_COMMIT : ST_ROLLBACK;
      end_q    <= upd_lsn_i;
    end
  end

  assign trid_o   = trid_q;
  assign first_o  = first_q;
  assign end_o    = end_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/redo_transaction_table_top.sv -----
// Top level of the redo transaction table: control sequencer and cell chain.
// Depends on rtt_pkg and rtt_cell.
//
// The table is a row of TABLE_DEPTH cells, cell 0 at the head. A log record is
// handled in S_IDLE, which registers the transaction id compare in every cell,
// and then in S_REC, which resolves the newest entry of that id along the chain
// and appends at the fill count or closes the open entry, unless the table is
// finalized or the record is at or past the boundary. Clear is done in S_IDLE
// and gives no result. Finalize and lookup sweep the chain one entry per
// cycle, shifting each cell towards the head while the head entry is examined
// and written back to the tail of the kept part, so the table keeps its
// order. Finalize then reads out the k committed entries by rotating the chain
// once more, one item per cycle while the output is taken; lookup gives its
// single item straight after the sweep. The input accepts an item only while
// the sequencer is idle; a result left in the output register does not stop
// records or clears. Configuration writes (the high boundary) are taken in
// any cycle.
`default_nettype none

module redo_transaction_table_top #(
  parameter int unsigned TABLE_DEPTH  = rtt_pkg::TableDepthDef,
  parameter int unsigned TRID_BITS    = rtt_pkg::TridBitsDef,
  parameter int unsigned LSN_BITS     = rtt_pkg::LsnBitsDef,
  localparam int unsigned IN_TDATA_W  = ((TRID_BITS + LSN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((TRID_BITS + 3 * LSN_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration: high_lsn_boundary
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [LSN_BITS-1:0]    cfg_data_i,
  // input items
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // trans_id, record_lsn
  input  wire logic [3:0]             s_axis_tuser_i,  // func, rec_kind
  // result items
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // entry_trans_id, entry_first_lsn, entry_end_lsn, high_rcv_lsn, table_overflow
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic [0:0]                  m_axis_tuser_o,  // entry_valid
  output logic                        m_axis_tlast_o   // last_result
);
  import rtt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_SWEEP,
    S_EMIT,
    S_RESP
  } state_e;

  // ---------------------------------------------------------------------------
  // Item fields
  // ---------------------------------------------------------------------------
  logic                 s_accept;
  logic [TRID_BITS-1:0] s_tid;
  logic [LSN_BITS-1:0]  s_lsn;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_tid    = s_axis_tdata_i[TRID_BITS-1:0];
  assign s_lsn    = s_axis_tdata_i[TRID_BITS +: LSN_BITS];

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 fin_q, fin_d;
  logic [LSN_BITS-1:0]  bound_q, bound_d;
  func_e                func_q, func_d;
  kind_e                kind_q, kind_d;
  logic [TRID_BITS-1:0] tid_q, tid_d;
  logic [LSN_BITS-1:0]  lsn_q, lsn_d;
  logic [CNT_W-1:0]     step_q, step_d;
  logic [CNT_W-1:0]     curn_q, curn_d;
  logic [LSN_BITS-1:0]  high_q, high_d;
  logic                 found_q, found_d;
  logic [TRID_BITS-1:0] hit_trid_q, hit_trid_d;
  logic [LSN_BITS-1:0]  hit_first_q, hit_first_d;
  logic [LSN_BITS-1:0]  hit_end_q, hit_end_d;
  // output register
  logic                 out_v_q, out_v_d;
  logic                 out_valid_q, out_valid_d;
  logic [TRID_BITS-1:0] out_trid_q, out_trid_d;
  logic [LSN_BITS-1:0]  out_first_q, out_first_d;
  logic [LSN_BITS-1:0]  out_end_q, out_end_d;
  logic [LSN_BITS-1:0]  out_high_q, out_high_d;
  logic                 out_ovf_q, out_ovf_d;
  logic                 out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  cell_ctrl_t           ctrl;
  logic [IDX_W-1:0]     ins_idx;
  logic [TRID_BITS-1:0] ins_trid;
  logic [LSN_BITS-1:0]  ins_first, ins_end;
  logic [1:0]           ins_status;
  logic [TRID_BITS-1:0] cap_tid;

  logic [TRID_BITS-1:0] c_trid   [TABLE_DEPTH];
  logic [LSN_BITS-1:0]  c_first  [TABLE_DEPTH];
  logic [LSN_BITS-1:0]  c_end    [TABLE_DEPTH];
  logic [1:0]           c_status [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] c_found;
  logic [TABLE_DEPTH-1:0] open_hit;
  logic                 any_open;

  // compare bus: the arriving id while capturing, the held id otherwise
  assign cap_tid  = ctrl.capture ? s_tid : tid_q;
  assign any_open = |open_hit;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int unsigned UP = (i == TABLE_DEPTH - 1) ? i : i + 1;
    logic found_above;

    // top cell has nothing above it; its shift input is don't-care
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign found_above = 1'b0;
    end else begin : g_mid
      assign found_above = c_found[UP];
    end

    rtt_cell #(
      .IDX        (i),
      .TABLE_DEPTH(TABLE_DEPTH),
      .TRID_BITS  (TRID_BITS),
      .LSN_BITS   (LSN_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .tid_i        (cap_tid),
      .upd_lsn_i    (lsn_q),
      .ins_idx_i    (ins_idx),
      .ins_trid_i   (ins_trid),
      .ins_first_i  (ins_first),
      .ins_end_i    (ins_end),
      .ins_status_i (ins_status),
      .up_trid_i    (c_trid[UP]),
      .up_first_i   (c_first[UP]),
      .up_end_i     (c_end[UP]),
      .up_status_i  (c_status[UP]),
      .found_above_i(found_above),
      .trid_o       (c_trid[i]),
      .first_o      (c_first[i]),
      .end_o        (c_end[i]),
      .status_o     (c_status[i]),
      .found_o      (c_found[i]),
      .open_hit_o   (open_hit[i])
    );
  end

  // head of the chain
  logic                 head_commit;
  logic                 keep;
  logic                 out_free;
  logic [CNT_W-1:0]     curn_m1, count_m1;

  assign head_commit = (c_status[0] == ST_COMMIT);
  assign out_free    = !out_v_q || m_axis_tready_i;
  assign curn_m1     = curn_q - CNT_W'(1);
  assign count_m1    = count_q - CNT_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    fin_d       = fin_q;
    bound_d     = bound_q;
    func_d      = func_q;
    kind_d      = kind_q;
    tid_d       = tid_q;
    lsn_d       = lsn_q;
    step_d      = step_q;
    curn_d      = curn_q;
    high_d      = high_q;
    found_d     = found_q;
    hit_trid_d  = hit_trid_q;
    hit_first_d = hit_first_q;
    hit_end_d   = hit_end_q;
    out_v_d     = out_v_q;
    out_valid_d = out_valid_q;
    out_trid_d  = out_trid_q;
    out_first_d = out_first_q;
    out_end_d   = out_end_q;
    out_high_d  = out_high_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;

    ctrl       = '0;
    keep       = 1'b0;
    ins_idx    = curn_m1[IDX_W-1:0];
    ins_trid   = c_trid[0];
    ins_first  = c_first[0];
    ins_end    = c_end[0];
    ins_status = c_status[0];

    if (out_v_q && m_axis_tready_i) begin
      out_v_d = 1'b0;
    end

    if (cfg_valid_i) begin
      bound_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          func_d       = func_e'(s_axis_tuser_i[1:0]);
          kind_d       = kind_e'(s_axis_tuser_i[3:2]);
          tid_d        = s_tid;
          lsn_d        = s_lsn;
          ctrl.capture = 1'b1;
          step_d       = '0;
          curn_d       = count_q;
          high_d       = '0;
          found_d      = 1'b0;
          case (func_e'(s_axis_tuser_i[1:0]))
            FUNC_RECORD: begin
              state_d = S_REC;
            end
            FUNC_FINALIZE: begin
              if (count_q == '0) begin
                fin_d   = 1'b1;
                state_d = S_EMIT;
              end else begin
                state_d = S_SWEEP;
              end
            end
            FUNC_LOOKUP: begin
              state_d = (count_q == '0) ? S_RESP : S_SWEEP;
            end
            FUNC_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
              fin_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_REC: begin
        state_d = S_IDLE;
        // finalized table and records at or past the boundary are left alone
        if (!fin_q && (lsn_q < bound_q)) begin
          case (kind_q)
            KIND_LOGICAL: begin
              if (!any_open) begin
                if (count_q == CNT_W'(TABLE_DEPTH)) begin
                  ovf_d = 1'b1;
                end else begin
                  ctrl.ins_en = 1'b1;
                  ins_idx     = count_q[IDX_W-1:0];
                  ins_trid    = tid_q;
                  ins_first   = lsn_q;
                  ins_end     = '0;
                  ins_status  = ST_OPEN;
                  count_d     = count_q + CNT_W'(1);
                end
              end
            end
            KIND_COMMIT, KIND_ROLLBACK: begin
              ctrl.upd_en     = 1'b1;
              ctrl.upd_commit = (kind_q == KIND_COMMIT);
            end
            default: ;
          endcase
        end
      end

      S_SWEEP: begin
        // head leaves, chain moves up, a kept head re-enters at the kept tail
        ctrl.shift  = 1'b1;
        keep        = (func_q == FUNC_FINALIZE) ? head_commit : 1'b1;
        ctrl.ins_en = keep;
        ins_idx     = curn_m1[IDX_W-1:0];
        if (!keep) begin
          curn_d = curn_m1;
        end
        if (head_commit && (c_end[0] > high_q)) begin
          high_d = c_end[0];
        end
        if ((func_q == FUNC_LOOKUP) && !found_q && head_commit &&
            (c_trid[0] == tid_q) && (c_first[0] <= lsn_q) && (c_end[0] >= lsn_q)) begin
          found_d     = 1'b1;
          hit_trid_d  = c_trid[0];
          hit_first_d = c_first[0];
          hit_end_d   = c_end[0];
        end
        step_d = step_q + CNT_W'(1);
        if (step_q == count_m1) begin
          step_d = '0;
          if (func_q == FUNC_FINALIZE) begin
            count_d = curn_d;
            fin_d   = 1'b1;
            state_d = S_EMIT;
          end else begin
            state_d = S_RESP;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_high_d = high_q;
          out_ovf_d  = ovf_q;
          if (count_q == '0) begin
            // nothing committed: one empty item
            out_valid_d = 1'b0;
            out_trid_d  = '0;
            out_first_d = '0;
            out_end_d   = '0;
            out_last_d  = 1'b1;
            state_d     = S_IDLE;
          end else begin
            out_valid_d = 1'b1;
            out_trid_d  = c_trid[0];
            out_first_d = c_first[0];
            out_end_d   = c_end[0];
            out_last_d  = (step_q == count_m1);
            // rotate so the table is back in order after the run
            ctrl.shift  = 1'b1;
            ctrl.ins_en = 1'b1;
            ins_idx     = count_m1[IDX_W-1:0];
            step_d      = step_q + CNT_W'(1);
            if (step_q == count_m1) begin
              state_d = S_IDLE;
            end
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_valid_d = found_q;
          out_trid_d  = found_q ? hit_trid_q : '0;
          out_first_d = found_q ? hit_first_q : '0;
          out_end_d   = found_q ? hit_end_q : '0;
          out_high_d  = high_q;
          out_ovf_d   = ovf_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
      bound_q <= '1;
      out_v_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      fin_q       <= fin_d;
      bound_q     <= bound_d;
      out_v_q     <= out_v_d;
      func_q      <= func_d;
      kind_q      <= kind_d;
      tid_q       <= tid_d;
      lsn_q       <= lsn_d;
      step_q      <= step_d;
      curn_q      <= curn_d;
      high_q      <= high_d;
      found_q     <= found_d;
      hit_trid_q  <= hit_trid_d;
      hit_first_q <= hit_first_d;
      hit_end_q   <= hit_end_d;
      out_valid_q <= out_valid_d;
      out_trid_q  <= out_trid_d;
      out_first_q <= out_first_d;
      out_end_q   <= out_end_d;
      out_high_q  <= out_high_d;
      out_ovf_q   <= out_ovf_d;
      out_last_q  <= out_last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_ovf_q, out_high_q, out_end_q,
                                         out_first_q, out_trid_q});
  assign m_axis_tuser_o  = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_one_newest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REC) |-> $onehot0(open_hit))
    else $error("more than one newest open entry on the chain");

  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> ($past(count_q) == CNT_W'(TABLE_DEPTH)))
    else $error("overflow raised with room in the table");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for redo_transaction_table_top: streams log records, finalize,
// lookup and clear items and checks every result item against a cycle-free predictor.
// Depends on rtt_pkg and the redo_transaction_table_top RTL.
`timescale 1ns / 100ps

module testbench;
  import rtt_pkg::*;

  localparam int DEPTH  = TableDepthDef;
  localparam int TRID_W = TridBitsDef;
  localparam int LSN_W  = LsnBitsDef;
  localparam int IN_W   = ((TRID_W + LSN_W + 7) / 8) * 8;
  localparam int OUT_W  = ((TRID_W + 3 * LSN_W + 1 + 7) / 8) * 8;
  // finalize sweeps n entries and rotates k more; allow both plus some slack
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

  // one result item, unpacked
  typedef struct {
    bit                valid;
    logic [TRID_W-1:0] tid;
    logic [LSN_W-1:0]  start_pos;
    logic [LSN_W-1:0]  end_lsn;
    logic [LSN_W-1:0]  high_lsn;
    bit                overflow;
    bit                last;
  } table_result_t;

  // Predicts the transaction table and holds the result items still due.
  class redo_table_scoreboard;
    logic [LSN_W-1:0]  boundary;
    logic [TRID_W-1:0] cell_tid   [DEPTH];
    logic [LSN_W-1:0]  cell_first [DEPTH];
    logic [LSN_W-1:0]  cell_end   [DEPTH];
    status_e           cell_state [DEPTH];
    int                fill;
    bit                overflow;
    bit                finalized;
    table_result_t     outstanding[$];
    int                errors;

    function new();
      boundary  = '1;
      fill      = 0;
      overflow  = 1'b0;
      finalized = 1'b0;
      errors    = 0;
    endfunction

    function void set_boundary(logic [LSN_W-1:0] v);
      boundary = v;
    endfunction

    function int pending();
      return outstanding.size();
    endfunction

    // newest entry of a transaction, -1 if it has none
    function int newest_entry(logic [TRID_W-1:0] t);
      for (int i = fill - 1; i >= 0; i--)
        if (cell_tid[i] == t) return i;
      return -1;
    endfunction

    function logic [LSN_W-1:0] redo_watermark();
      logic [LSN_W-1:0] m;
      m = '0;
      for (int i = 0; i < fill; i++)
        if (cell_state[i] == ST_COMMIT && cell_end[i] > m) m = cell_end[i];
      return m;
    endfunction

    function table_result_t entry_result(bit hit, int idx, logic [LSN_W-1:0] hw, bit last_one);
      table_result_t r;
      r.valid     = hit;
      r.tid       = hit ? cell_tid[idx] : '0;
      r.start_pos = hit ? cell_first[idx] : '0;
      r.end_lsn   = hit ? cell_end[idx] : '0;
      r.high_lsn  = hw;
      r.overflow  = overflow;
      r.last      = last_one;
      return r;
    endfunction

    // Applies one accepted input item; returns 0 if the block merely ignores it.
    function bit note_item(func_e f, kind_e k, logic [TRID_W-1:0] tid, logic [LSN_W-1:0] lsn);
      int n;
      int kept;
      logic [LSN_W-1:0] hw;
      case (f)
        FUNC_RECORD: begin
          if (finalized || lsn >= boundary || k == KIND_OTHER) return 1'b0;
          n = newest_entry(tid);
          if (k == KIND_LOGICAL) begin
            if (n < 0 || cell_state[n] != ST_OPEN) begin
              if (fill >= DEPTH) begin
                overflow = 1'b1;
              end else begin
                cell_tid[fill]   = tid;
                cell_first[fill] = lsn;
                cell_end[fill]   = '0;
                cell_state[fill] = ST_OPEN;
                fill++;
              end
            end
          end else if (n >= 0 && cell_state[n] == ST_OPEN) begin
            cell_state[n] = (k == KIND_COMMIT) ? ST_COMMIT : ST_ROLLBACK;
            cell_end[n]   = lsn;
          end
        end
        FUNC_CLEAR: begin
          fill      = 0;
          overflow  = 1'b0;
          finalized = 1'b0;
        end
        FUNC_FINALIZE: begin
          // squeeze out everything not committed, keeping table order
          kept = 0;
          for (int i = 0; i < fill; i++) begin
            if (cell_state[i] == ST_COMMIT) begin
              cell_tid[kept]   = cell_tid[i];
              cell_first[kept] = cell_first[i];
              cell_end[kept]   = cell_end[i];
              cell_state[kept] = ST_COMMIT;
              kept++;
            end
          end
          fill      = kept;
          finalized = 1'b1;
          hw        = redo_watermark();
          if (kept == 0) outstanding.push_back(entry_result(1'b0, 0, hw, 1'b1));
          for (int i = 0; i < kept; i++)
            outstanding.push_back(entry_result(1'b1, i, hw, i == kept - 1));
        end
        default: begin
          hw = redo_watermark();
          for (int i = 0; i < fill; i++) begin
            if (cell_state[i] == ST_COMMIT && cell_tid[i] == tid &&
                cell_first[i] <= lsn && cell_end[i] >= lsn) begin
              outstanding.push_back(entry_result(1'b1, i, hw, 1'b1));
              return 1'b1;
            end
          end
          outstanding.push_back(entry_result(1'b0, 0, hw, 1'b1));
        end
      endcase
      return 1'b1;
    endfunction

    task flag_error(string msg);
      errors++;
      $display("[%0t] check error: %s", $time, msg);
    endtask

    task check_result(table_result_t got);
      table_result_t want;
      if (outstanding.size() == 0) begin
        flag_error("result item with nothing outstanding");
        return;
      end
      want = outstanding.pop_front();
      if (got.valid !== want.valid)
        flag_error($sformatf("entry_valid %0b, want %0b", got.valid, want.valid));
      if (got.tid !== want.tid)
        flag_error($sformatf("entry_trans_id %0h, want %0h", got.tid, want.tid));
      if (got.start_pos !== want.start_pos)
        flag_error($sformatf("entry start position %0h, want %0h", got.start_pos,
                             want.start_pos));
      if (got.end_lsn !== want.end_lsn)
        flag_error($sformatf("entry_end_lsn %0h, want %0h", got.end_lsn, want.end_lsn));
      if (got.high_lsn !== want.high_lsn)
        flag_error($sformatf("high_rcv_lsn %0h, want %0h", got.high_lsn, want.high_lsn));
      if (got.overflow !== want.overflow)
        flag_error($sformatf("table_overflow %0b, want %0b", got.overflow, want.overflow));
      if (got.last !== want.last)
        flag_error($sformatf("last_result %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LSN_W-1:0] cfg_data;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;   // trans_id, record_lsn
  logic [3:0]       s_tuser;   // func, rec_kind
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // entry_trans_id, entry start, entry_end_lsn,
                               // high_rcv_lsn, table_overflow
  logic [0:0]       m_tuser;   // entry_valid
  logic             m_tlast;   // last_result

  redo_table_scoreboard sb = new();

  bit               pace_idle;       // random gaps on both sides when set
  logic [LSN_W-1:0] lsn_cursor;      // running log position of the scan

  always #4 clk_i = ~clk_i;

  redo_transaction_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  function automatic logic [LSN_W-1:0] rand_lsn();
    return LSN_W'({$urandom, $urandom});
  endfunction

  // Offers one item, after an optional gap, and notes it at the accepting edge.
  // tvalid is only dropped when a gap follows, so it never toggles within a step.
  task automatic send_item(func_e f, kind_e k, logic [TRID_W-1:0] tid,
                           logic [LSN_W-1:0] lsn);
    int gap;
    gap = pace_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({lsn, tid});
    s_tuser  <= {k, f};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    void'(sb.note_item(f, k, tid, lsn));
  endtask

  // Stops offering, waits for every due result, then lets the block go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_boundary(logic [LSN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.set_boundary(v);
    cfg_valid <= 1'b0;
  endtask

  // Fills the table past its depth with fresh transactions, then commits a few.
  task automatic flood_table(inout int used);
    logic [TRID_W-1:0] base;
    base = TRID_W'($urandom_range(0, 65535));
    for (int j = 0; j < DEPTH + 2; j++) begin
      lsn_cursor += LSN_W'(1);
      send_item(FUNC_RECORD, KIND_LOGICAL, base + TRID_W'(j), lsn_cursor);
      used++;
    end
    for (int j = 0; j < 6; j++) begin
      lsn_cursor += LSN_W'(1);
      send_item(FUNC_RECORD, KIND_COMMIT, base + TRID_W'($urandom_range(0, DEPTH + 1)),
                lsn_cursor);
      used++;
    end
  endtask

  // Random scan: mostly records of a few interleaved transactions at rising
  // positions, lookups near the recent positions, the odd finalize or clear,
  // and some items with every field random.
  task automatic run_phase(int budget, logic [LSN_W-1:0] bound, bit with_flood);
    logic [TRID_W-1:0] pool [4];
    int used;
    int r;
    int w;
    kind_e k;
    used = 0;
    for (int i = 0; i < 4; i++) pool[i] = TRID_W'($urandom_range(0, 65535));
    // either side of the boundary, on a clean table
    send_item(FUNC_CLEAR, KIND_LOGICAL, '0, '0);
    if (bound != '0) begin
      send_item(FUNC_RECORD, KIND_LOGICAL, pool[0], bound - LSN_W'(1));
      send_item(FUNC_RECORD, KIND_COMMIT, pool[0], bound);
      send_item(FUNC_RECORD, KIND_COMMIT, pool[0], bound - LSN_W'(1));
      send_item(FUNC_LOOKUP, KIND_LOGICAL, pool[0], bound - LSN_W'(1));
    end
    if (with_flood) flood_table(used);
    while (used < budget) begin
      r = $urandom_range(0, 99);
      if (sb.finalized && r < 25) begin
        send_item(FUNC_CLEAR, kind_e'($urandom_range(0, 3)), pool[0], lsn_cursor);
      end else if (r < 60) begin
        w = $urandom_range(0, 99);
        k = (w < 50) ? KIND_LOGICAL : (w < 78) ? KIND_COMMIT :
            (w < 93) ? KIND_ROLLBACK : KIND_OTHER;
        lsn_cursor += LSN_W'($urandom_range(1, 16));
        send_item(FUNC_RECORD, k, pool[2'($urandom_range(0, 3))], lsn_cursor);
      end else if (r < 75) begin
        send_item(FUNC_LOOKUP, kind_e'($urandom_range(0, 3)),
                  pool[2'($urandom_range(0, 3))],
                  lsn_cursor - LSN_W'($urandom_range(0, 64)));
      end else if (r < 80) begin
        send_item(FUNC_FINALIZE, kind_e'($urandom_range(0, 3)), pool[0], lsn_cursor);
      end else if (r < 83) begin
        send_item(FUNC_CLEAR, kind_e'($urandom_range(0, 3)), pool[1], lsn_cursor);
      end else if (r < 84) begin
        flood_table(used);
      end else begin
        send_item(func_e'($urandom_range(0, 3)), kind_e'($urandom_range(0, 3)),
                  TRID_W'($urandom_range(0, 65535)), rand_lsn());
      end
      used++;
    end
  endtask

  // Result side: random stall per item, check at the accepting edge.
  initial begin
    int gap;
    table_result_t got;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pace_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      got.valid     = m_tuser[0];
      got.tid       = m_tdata[TRID_W-1:0];
      got.start_pos = m_tdata[TRID_W +: LSN_W];
      got.end_lsn   = m_tdata[TRID_W + LSN_W +: LSN_W];
      got.high_lsn  = m_tdata[TRID_W + 2 * LSN_W +: LSN_W];
      got.overflow  = m_tdata[TRID_W + 3 * LSN_W];
      got.last      = m_tlast;
      sb.check_result(got);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [LSN_W-1:0] top;
    logic [LSN_W-1:0] bound;
    top       = '1;
    pace_idle = 1'b1;
    rst_ni    <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, boundary still at its reset value (all ones).
    send_item(FUNC_FINALIZE, KIND_LOGICAL, '0, '0);            // nothing committed
    send_item(FUNC_CLEAR, KIND_LOGICAL, '0, '0);
    send_item(FUNC_LOOKUP, KIND_LOGICAL, '0, '0);              // empty table
    send_item(FUNC_RECORD, KIND_LOGICAL, 16'h0000, 48'd10);
    send_item(FUNC_RECORD, KIND_LOGICAL, 16'h0000, 48'd11);    // still open, no append
    send_item(FUNC_LOOKUP, KIND_LOGICAL, 16'h0000, 48'd10);    // open entries never match
    send_item(FUNC_RECORD, KIND_COMMIT, 16'h0000, 48'd20);
    send_item(FUNC_LOOKUP, KIND_LOGICAL, 16'h0000, 48'd10);    // span starts here
    send_item(FUNC_LOOKUP, KIND_COMMIT, 16'h0000, 48'd20);     // span ends here
    send_item(FUNC_LOOKUP, KIND_LOGICAL, 16'h0000, 48'd21);    // just past the span
    send_item(FUNC_RECORD, KIND_LOGICAL, 16'hffff, 48'd30);
    send_item(FUNC_RECORD, KIND_ROLLBACK, 16'hffff, 48'd40);
    send_item(FUNC_LOOKUP, KIND_LOGICAL, 16'hffff, 48'd35);    // rolled back, no match
    send_item(FUNC_RECORD, KIND_OTHER, 16'h0005, 48'd50);      // other kind ignored
    send_item(FUNC_RECORD, KIND_COMMIT, 16'h0007, 48'd55);     // commit of unknown id
    send_item(FUNC_RECORD, KIND_LOGICAL, 16'h0000, 48'd60);    // newest closed: append
    send_item(FUNC_RECORD, KIND_LOGICAL, 16'h1234, top - LSN_W'(1));
    send_item(FUNC_RECORD, KIND_LOGICAL, 16'h4321, top);       // at the boundary
    send_item(FUNC_RECORD, KIND_COMMIT, 16'h1234, top - LSN_W'(1));
    send_item(FUNC_FINALIZE, KIND_LOGICAL, '0, '0);
    send_item(FUNC_RECORD, KIND_LOGICAL, 16'h0009, 48'd70);    // after finalize: ignored
    send_item(FUNC_FINALIZE, KIND_LOGICAL, '0, '0);            // same entries again
    send_item(FUNC_LOOKUP, KIND_LOGICAL, 16'h1234, top - LSN_W'(1));
    send_item(FUNC_CLEAR, KIND_LOGICAL, '0, '0);
    send_item(FUNC_LOOKUP, KIND_LOGICAL, 16'h0000, 48'd15);    // gone after clear

    // Random part: boundary at both extremes and in between, some phases at
    // full rate on both sides.
    for (int p = 0; p < 6; p++) begin
      settle();
      pace_idle  = (p % 3 != 2);
      lsn_cursor = rand_lsn() >> 1;
      case (p)
        0:       bound = '1;
        1:       bound = '0;
        2:       bound = lsn_cursor + LSN_W'($urandom_range(200, 600));
        3:       bound = LSN_W'(1);
        4:       bound = rand_lsn();
        default: bound = '1;
      endcase
      write_boundary(bound);
      run_phase((p == 1 || p == 3) ? 25 : 80, bound, p == 0);
    end

    settle();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_cell.sv
hw/rtl/redo_transaction_table_top.sv
bench/testbench.sv
